[hw/rtl/imgcc_pkg.sv]
// Shared types and constants of the image convolution clamp block.
// No dependencies; used by the stream interfaces and the RTL modules.
`default_nettype none
package imgcc_pkg;

    localparam int PIX_W     = 8;
    localparam int KSIZE_W   = 3;
    localparam int DIM_W     = 11;
    localparam int COEF_W    = 8;
    localparam int KROW_COLS = 5;
    localparam int KROW_W    = KROW_COLS * COEF_W;
    localparam int NUM_KROWS = 5;
    localparam int APB_DW    = 64;
    localparam int APB_AW    = 6;
    localparam int MAX_HEIGHT = 1024;
    localparam int PROD_W    = PIX_W + COEF_W + 1;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    // register map, one 64-bit register every 8 bytes
    typedef enum logic [2:0] {
        REG_KSIZE  = 3'd0,
        REG_WIDTH  = 3'd1,
        REG_HEIGHT = 3'd2,
        REG_KROW0  = 3'd3,
        REG_KROW1  = 3'd4,
        REG_KROW2  = 3'd5,
        REG_KROW3  = 3'd6,
        REG_KROW4  = 3'd7
    } t_reg_idx;

endpackage
`default_nettype wire

[hw/rtl/imgcc_if.sv]
// Valid/ready stream interfaces for pixel words in and result words out.
// Depends on imgcc_pkg.
`default_nettype none
interface imgcc_pix_if import imgcc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] in_pixel;
    modport source (output valid, output in_pixel, input ready);
    modport sink   (input valid, input in_pixel, output ready);
endinterface

interface imgcc_res_if import imgcc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_pixel;
    logic             row_end;
    logic             frame_end;
    modport source (output valid, output out_pixel, output row_end, output frame_end,
                    input ready);
    modport sink   (input valid, input out_pixel, input row_end, input frame_end,
                    output ready);
endinterface
`default_nettype wire

[hw/rtl/imgcc_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on imgcc_pkg only through the import convention.
`default_nettype none
module imgcc_ram import imgcc_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write, then registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

[hw/rtl/image_convolution_clamp_core.sv]
// Streaming valid-region 2-D convolution with 0..255 clamp.
// Pixel words enter on i_pix in raster order; one result word per pixel that
// completes an N x N window leaves on o_res, with row_end and frame_end flags.
// The output frame is (W-N+1) x (H-N+1). The user is to write configuration
// over the APB port (8-byte spaced 64-bit registers) only while the block is
// idle; the block itself does not enforce this. Throughput: one pixel per cycle
// while o_res is not stalled. Register stages: five (RAM read, window,
// products, row sums, clamp/output); o_res is driven from the last of them.
// The rate is set by the line ring: MAX_KERNEL RAMs of MAX_WIDTH pixels, each
// read once per pixel; only the RAM of the current ring slot is written.
// Every pipeline stage has its own valid bit and advances when the stage
// after it is empty or moving, so input is still taken while a result waits
// as long as a bubble is left in the pipe; a stalled o_res backs up one stage
// at a time until i_pix.ready drops.
// Reset (i_rst_n low, synchronous) clears the counters, the pipeline valid
// bits and the registers to kernel size 3, 1024 x 1024, all coefficients 0.
// Line RAM contents are not cleared and need no clearing pass.
// Depends on imgcc_pkg, imgcc_if and imgcc_ram.
`default_nettype none
module image_convolution_clamp_core import imgcc_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    imgcc_pix_if.sink              i_pix,
    imgcc_res_if.source            o_res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);
    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int CNT_W  = (AW + 1 > DIM_W) ? AW + 1 : DIM_W;
    localparam int RING_W = $clog2(MAX_KERNEL);
    localparam int ROW_W  = 10;
    localparam int KTOP   = (MAX_KERNEL < NUM_KROWS) ? MAX_KERNEL : NUM_KROWS;
    localparam int RSUM_W = PROD_W + $clog2(MAX_KERNEL);
    localparam int SUM_W  = RSUM_W + $clog2(MAX_KERNEL);

    // ---------------- configuration registers ----------------
    logic [KSIZE_W-1:0] r_ksize;
    logic [DIM_W-1:0]   r_width;
    logic [DIM_W-1:0]   r_height;
    logic [KROW_W-1:0]  r_krow [NUM_KROWS];
    logic               cfg_wr;
    t_reg_idx           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[5:3]);
    assign cfg_wr  = psel && penable && pwrite;

    // take register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ksize  <= KSIZE_W'(3);
            r_width  <= DIM_W'(1024);
            r_height <= DIM_W'(1024);
            for (int i = 0; i < NUM_KROWS; i++) begin
                r_krow[i] <= '0;
            end
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_KSIZE:  r_ksize     <= pwdata[KSIZE_W-1:0];
                REG_WIDTH:  r_width     <= pwdata[DIM_W-1:0];
                REG_HEIGHT: r_height    <= pwdata[DIM_W-1:0];
                REG_KROW0:  r_krow[0]   <= pwdata[KROW_W-1:0];
                REG_KROW1:  r_krow[1]   <= pwdata[KROW_W-1:0];
                REG_KROW2:  r_krow[2]   <= pwdata[KROW_W-1:0];
                REG_KROW3:  r_krow[3]   <= pwdata[KROW_W-1:0];
                REG_KROW4:  r_krow[4]   <= pwdata[KROW_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (cfg_idx)
            REG_KSIZE:  prdata = APB_DW'(r_ksize);
            REG_WIDTH:  prdata = APB_DW'(r_width);
            REG_HEIGHT: prdata = APB_DW'(r_height);
            REG_KROW0:  prdata = APB_DW'(r_krow[0]);
            REG_KROW1:  prdata = APB_DW'(r_krow[1]);
            REG_KROW2:  prdata = APB_DW'(r_krow[2]);
            REG_KROW3:  prdata = APB_DW'(r_krow[3]);
            REG_KROW4:  prdata = APB_DW'(r_krow[4]);
            default:    prdata = '0;
        endcase
    end

    // effective kernel side, width and height after clamping
    logic [KSIZE_W-1:0] eff_n;
    logic [CNT_W-1:0]   eff_w;
    logic [DIM_W-1:0]   eff_h;

    always_comb begin
        eff_n = r_ksize;
        if (eff_n < KSIZE_W'(3)) eff_n = KSIZE_W'(3);
        if (eff_n > KSIZE_W'(KTOP)) eff_n = KSIZE_W'(KTOP);
        eff_w = CNT_W'(r_width);
        if (eff_w == '0) eff_w = CNT_W'(1);
        if (eff_w > CNT_W'(MAX_WIDTH)) eff_w = CNT_W'(MAX_WIDTH);
        eff_h = r_height;
        if (eff_h == '0) eff_h = DIM_W'(1);
        if (eff_h > DIM_W'(MAX_HEIGHT)) eff_h = DIM_W'(MAX_HEIGHT);
    end

    // coefficient that meets window tap (d rows back, k columns back)
    logic signed [COEF_W-1:0] coef [MAX_KERNEL][MAX_KERNEL];

    always_comb begin
        logic [KSIZE_W-1:0] ky;
        logic [KSIZE_W-1:0] kx;
        for (int d = 0; d < MAX_KERNEL; d++) begin
            for (int k = 0; k < MAX_KERNEL; k++) begin
                ky = eff_n - KSIZE_W'(1) - KSIZE_W'(d);
                kx = eff_n - KSIZE_W'(1) - KSIZE_W'(k);
                if (KSIZE_W'(d) < eff_n && KSIZE_W'(k) < eff_n) begin
                    coef[d][k] = r_krow[ky][COEF_W*kx +: COEF_W];
                end else begin
                    coef[d][k] = '0;
                end
            end
        end
    end

    // ---------------- pipeline flow control ----------------
    logic r1_v, r2_v, r3_v, r4_v, r5_v;
    logic en1, en2, en3, en4, en5;
    logic accept;

    assign en5 = !r5_v || o_res.ready;
    assign en4 = !r4_v || en5;
    assign en3 = !r3_v || en4;
    assign en2 = !r2_v || en3;
    assign en1 = !r1_v || en2;
    assign i_pix.ready = en1;
    assign accept = i_pix.valid && en1;

    // ---------------- position counters ----------------
    logic [AW-1:0]     r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [RING_W-1:0] r_ring, n_ring;
    logic [CNT_W-1:0]  col_p1;
    logic [DIM_W-1:0]  row_p1;
    logic              last_col, last_row, produce;

    assign col_p1   = CNT_W'(r_col) + CNT_W'(1);
    assign row_p1   = DIM_W'(r_row) + DIM_W'(1);
    assign last_col = col_p1 >= eff_w;
    assign last_row = row_p1 >= eff_h;
    assign produce  = (col_p1 >= CNT_W'(eff_n)) && (row_p1 >= DIM_W'(eff_n));

    // advance column, row and ring slot
    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_ring = r_ring;
        if (last_col) begin
            n_col = '0;
            if (last_row) begin
                n_row  = '0;
                n_ring = '0;
            end else begin
                n_row  = r_row + ROW_W'(1);
                n_ring = (r_ring == RING_W'(MAX_KERNEL - 1)) ? '0 : r_ring + RING_W'(1);
            end
        end else begin
            n_col = col_p1[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_ring <= '0;
        end else if (accept) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_ring <= n_ring;
        end
    end

    // ---------------- line ring ----------------
    logic [PIX_W-1:0]      ram_q [MAX_KERNEL];
    logic [MAX_KERNEL-1:0] ram_we;

    for (genvar g = 0; g < MAX_KERNEL; g++) begin : g_line
        assign ram_we[g] = accept && (r_ring == RING_W'(g));
        imgcc_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (ram_we[g]),
            .i_waddr (r_col),
            .i_wdata (i_pix.in_pixel),
            .i_re    (accept),
            .i_raddr (r_col),
            .o_rdata (ram_q[g])
        );
    end

    // stage 1: pixel and its ring slot, beside the RAM read data
    logic [PIX_W-1:0]  r1_pix;
    logic [RING_W-1:0] r1_ring;
    logic              r1_prod, r1_rend, r1_fend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en1) begin
            r1_v <= accept;
        end
        if (accept) begin
            r1_pix  <= i_pix.in_pixel;
            r1_ring <= r_ring;
            r1_prod <= produce;
            r1_rend <= last_col;
            r1_fend <= last_col && last_row;
        end
    end

    // new window column: current pixel on top of the older rows
    logic [PIX_W-1:0] new_col [MAX_KERNEL];

    always_comb begin
        logic [RING_W:0] idx;
        new_col[0] = r1_pix;
        for (int d = 1; d < MAX_KERNEL; d++) begin
            if (r1_ring >= RING_W'(d)) begin
                idx = {1'b0, r1_ring} - (RING_W+1)'(d);
            end else begin
                idx = {1'b0, r1_ring} + (RING_W+1)'(MAX_KERNEL - d);
            end
            new_col[d] = ram_q[idx[RING_W-1:0]];
        end
    end

    // stage 2: sliding window, shifted by every pixel
    logic [PIX_W-1:0] r_win [MAX_KERNEL][MAX_KERNEL];
    logic             r2_rend, r2_fend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en2) begin
            r2_v <= r1_v && r1_prod;
        end
        if (en2 && r1_v) begin
            for (int d = 0; d < MAX_KERNEL; d++) begin
                r_win[d][0] <= new_col[d];
                for (int k = 1; k < MAX_KERNEL; k++) begin
                    r_win[d][k] <= r_win[d][k-1];
                end
            end
            r2_rend <= r1_rend;
            r2_fend <= r1_fend;
        end
    end

    // stage 3: products
    logic signed [PROD_W-1:0] r_prod [MAX_KERNEL][MAX_KERNEL];
    logic                     r3_rend, r3_fend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en3) begin
            r3_v <= r2_v;
        end
        if (en3) begin
            for (int d = 0; d < MAX_KERNEL; d++) begin
                for (int k = 0; k < MAX_KERNEL; k++) begin
                    r_prod[d][k] <= PROD_W'($signed({1'b0, r_win[d][k]}) * coef[d][k]);
                end
            end
            r3_rend <= r2_rend;
            r3_fend <= r2_fend;
        end
    end

    // stage 4: one sum per window row
    logic signed [RSUM_W-1:0] r_rsum [MAX_KERNEL];
    logic                     r4_rend, r4_fend;

    always_ff @(posedge i_clk) begin
        logic signed [RSUM_W-1:0] acc;
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en4) begin
            r4_v <= r3_v;
        end
        if (en4) begin
            for (int d = 0; d < MAX_KERNEL; d++) begin
                acc = '0;
                for (int k = 0; k < MAX_KERNEL; k++) begin
                    acc = acc + RSUM_W'(r_prod[d][k]);
                end
                r_rsum[d] <= acc;
            end
            r4_rend <= r3_rend;
            r4_fend <= r3_fend;
        end
    end

    // stage 5: total, clamp, result word
    logic signed [SUM_W-1:0] total;
    logic [PIX_W-1:0]        r5_pix;
    logic                    r5_rend, r5_fend;

    always_comb begin
        total = '0;
        for (int d = 0; d < MAX_KERNEL; d++) begin
            total = total + SUM_W'(r_rsum[d]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en5) begin
            r5_v <= r4_v;
        end
        if (en5) begin
            if (total < 0) begin
                r5_pix <= '0;
            end else if (total > SUM_W'(PIX_MAX)) begin
                r5_pix <= PIX_MAX;
            end else begin
                r5_pix <= total[PIX_W-1:0];
            end
            r5_rend <= r4_rend;
            r5_fend <= r4_fend;
        end
    end

    assign o_res.valid     = r5_v;
    assign o_res.out_pixel = r5_pix;
    assign o_res.row_end   = r5_rend;
    assign o_res.frame_end = r5_fend;

    // ---------------- checks ----------------
    a_accept_fills_s1 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r1_v)
        else $error("accepted pixel did not reach stage 1");

    a_one_ring_write : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> $onehot(ram_we))
        else $error("pixel written to other than one line RAM");

    a_ring_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ring <= RING_W'(MAX_KERNEL - 1))
        else $error("ring slot out of range");

    a_frame_has_row_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r5_v |-> (!r5_fend || r5_rend))
        else $error("frame end without row end");
endmodule
`default_nettype wire

[tb/tb_image_convolution_clamp_core.sv]
// Self-checking testbench of image_convolution_clamp_core: streams frames of
// random or constant pixels under several kernel and frame settings, checks each word.
// Depends on imgcc_pkg, imgcc_if and the RTL of the block.
`timescale 1ns / 1ps

// Predicts the convolution results and holds them until the block returns them.
class conv_scoreboard;
    typedef struct packed {
        logic [7:0] pix;
        logic       row_end;
        logic       frame_end;
    } t_conv_word;

    logic [7:0]  line_mem [5][1024];
    int          col;
    int          row;
    logic [2:0]  ksize;
    logic [10:0] width;
    logic [10:0] height;
    logic [39:0] krow [5];
    t_conv_word  expected_out [$];
    int          errors;

    function void reset_state();
        ksize  = 3;
        width  = 1024;
        height = 1024;
        foreach (krow[i]) krow[i] = '0;
        col    = 0;
        row    = 0;
        errors = 0;
    endfunction

    function void write_reg(imgcc_pkg::t_reg_idx idx, logic [63:0] v);
        case (idx)
            imgcc_pkg::REG_KSIZE:  ksize  = v[2:0];
            imgcc_pkg::REG_WIDTH:  width  = v[10:0];
            imgcc_pkg::REG_HEIGHT: height = v[10:0];
            default:               krow[idx - imgcc_pkg::REG_KROW0] = v[39:0];
        endcase
    endfunction

    function int eff_n();
        if (ksize < 3) return 3;
        if (ksize > 5) return 5;
        return ksize;
    endfunction

    function int eff_w();
        if (width == 0) return 1;
        if (width > 1024) return 1024;
        return width;
    endfunction

    function int eff_h();
        if (height == 0) return 1;
        if (height > 1024) return 1024;
        return height;
    endfunction

    // Store the pixel, emit a window sum when the window is complete, advance.
    function void note_pixel(logic [7:0] p);
        int n;
        int sum;
        bit last_col;
        bit last_row;
        t_conv_word w;
        n        = eff_n();
        last_col = (col + 1 >= eff_w());
        last_row = (row + 1 >= eff_h());
        line_mem[row % 5][col] = p;
        if (row + 1 >= n && col + 1 >= n) begin
            sum = 0;
            for (int ky = 0; ky < n; ky++) begin
                for (int kx = 0; kx < n; kx++) begin
                    sum += int'(line_mem[(row + 1 - n + ky) % 5][col + 1 - n + kx])
                         * int'($signed(krow[ky][8*kx +: 8]));
                end
            end
            if (sum < 0) sum = 0;
            if (sum > 255) sum = 255;
            w.pix       = sum[7:0];
            w.row_end   = last_col;
            w.frame_end = last_col && last_row;
            expected_out.push_back(w);
        end
        if (last_col) begin
            col = 0;
            row = last_row ? 0 : row + 1;
        end else begin
            col = col + 1;
        end
    endfunction

    function void check_result(logic [7:0] pix, logic re, logic fe);
        t_conv_word w;
        if (expected_out.size() == 0) begin
            $display("%0t: unexpected word pix=%0d row_end=%0b frame_end=%0b",
                     $time, pix, re, fe);
            errors++;
            return;
        end
        w = expected_out.pop_front();
        if (pix !== w.pix) begin
            $display("%0t: out_pixel expected %0d actual %0d", $time, w.pix, pix);
            errors++;
        end
        if (re !== w.row_end) begin
            $display("%0t: row_end expected %0b actual %0b", $time, w.row_end, re);
            errors++;
        end
        if (fe !== w.frame_end) begin
            $display("%0t: frame_end expected %0b actual %0b", $time, w.frame_end, fe);
            errors++;
        end
    endfunction
endclass

module tb_image_convolution_clamp_core;
    import imgcc_pkg::*;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    imgcc_pix_if pix ();
    imgcc_res_if res ();

    image_convolution_clamp_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_res   (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    conv_scoreboard sb = new();
    bit             no_idle = 1'b0;
    bit             pressure_done = 1'b0;
    int             stall_left = 0;
    int             random_pixels = 0;

    always #5 i_clk = ~i_clk;

    initial begin
        pix.valid    = 1'b0;
        pix.in_pixel = '0;
        res.ready    = 1'b0;
    end

    // Stall the result side: mostly short, a few long stretches.
    always @(posedge i_clk) begin
        int r;
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            res.ready  <= 1'b0;
        end else if (no_idle) begin
            res.ready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
                stall_left <= (r < 2) ? $urandom_range(10, 60) : $urandom_range(0, 3);
                res.ready  <= 1'b0;
            end else begin
                res.ready <= 1'b1;
            end
        end
    end

    // Check each result word as it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready)
            sb.check_result(res.out_pixel, res.row_end, res.frame_end);
    end

    initial begin
        #10ms;
        $display("DONE: errors detected");
        $finish;
    end

    function int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    task automatic apb_write(t_reg_idx idx, logic [63:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, v);
    endtask

    // Drain the pipe, then write every register.
    task automatic configure(logic [2:0] ks, logic [10:0] w, logic [10:0] h,
                             logic [39:0] k [5]);
        do @(posedge i_clk); while (sb.expected_out.size() != 0);
        repeat (20) @(posedge i_clk);
        apb_write(REG_KSIZE, 64'(ks));
        apb_write(REG_WIDTH, 64'(w));
        apb_write(REG_HEIGHT, 64'(h));
        apb_write(REG_KROW0, 64'(k[0]));
        apb_write(REG_KROW1, 64'(k[1]));
        apb_write(REG_KROW2, 64'(k[2]));
        apb_write(REG_KROW3, 64'(k[3]));
        apb_write(REG_KROW4, 64'(k[4]));
    endtask

    // Send whole frames; fill < 0 means random pixels, else a constant value.
    task automatic send_frames(int nfr, int fill);
        int total;
        int gap;
        logic [7:0] p;
        total = nfr * sb.eff_w() * sb.eff_h();
        for (int i = 0; i < total; i++) begin
            p   = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
            gap = pick_gap();
            if (gap > 0) begin
                pix.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pix.valid    <= 1'b1;
            pix.in_pixel <= p;
            do @(posedge i_clk); while (!pix.ready);
            sb.note_pixel(p);
            // hold off input until the block has returned everything
            if (fill < 0 && !pressure_done && i >= total / 2 &&
                sb.expected_out.size() != 0) begin
                pix.valid <= 1'b0;
                do @(posedge i_clk); while (sb.expected_out.size() != 0);
                pressure_done = 1'b1;
            end
        end
        pix.valid <= 1'b0;
    endtask

    function logic [39:0] rand_krow(int mode);
        logic [39:0] v;
        for (int c = 0; c < 5; c++) begin
            case (mode)
                0:       v[8*c +: 8] = 8'($urandom_range(0, 255));
                1:       v[8*c +: 8] = 8'($signed($urandom_range(0, 8)) - 4);
                default: v[8*c +: 8] = 8'($urandom_range(0, 2));
            endcase
        end
        return v;
    endfunction

    initial begin
        logic [39:0] k [5];
        logic [2:0]  ks;
        logic [10:0] w;
        logic [10:0] h;
        int          r;
        int          kmode;

        sb.reset_state();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Largest positive coefficients on full-scale pixels: clamp high.
        foreach (k[i]) k[i] = {5{8'h7F}};
        configure(3'd3, 11'd5, 11'd5, k);
        send_frames(1, 255);
        send_frames(1, 0);
        // Most negative coefficients, 5x5 on a 5x5 frame: clamp low.
        foreach (k[i]) k[i] = {5{8'h80}};
        configure(3'd5, 11'd5, 11'd5, k);
        send_frames(1, 255);
        // Kernel size below range and width of zero: no results, counters wrap.
        configure(3'd0, 11'd0, 11'd3, k);
        send_frames(2, -1);
        // Kernel size above range and frame narrower than the kernel.
        configure(3'd7, 11'd4, 11'd6, k);
        send_frames(1, -1);
        // Identity kernel of size 4.
        foreach (k[i]) k[i] = '0;
        k[1] = 40'h00_00_01_00_00;
        configure(3'd4, 11'd7, 11'd6, k);
        send_frames(1, -1);

        // Oversize width on a one-row frame: the column runs to the widest row and wraps.
        foreach (k[i]) k[i] = rand_krow(2);
        no_idle = 1'b1;
        configure(3'd5, 11'd2047, 11'd1, k);
        send_frames(1, -1);
        no_idle = 1'b0;

        // Random settings on small frames.
        while (random_pixels < 500) begin
            r  = $urandom_range(0, 99);
            ks = (r < 10) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(3, 5));
            w  = (r < 8) ? 11'($urandom_range(0, 4)) : 11'($urandom_range(5, 16));
            h  = (r >= 92) ? 11'($urandom_range(0, 4)) : 11'($urandom_range(5, 10));
            kmode = $urandom_range(0, 2);
            foreach (k[i]) k[i] = rand_krow(kmode);
            no_idle = ($urandom_range(0, 5) == 0);
            configure(ks, w, h, k);
            r = $urandom_range(1, 2);
            random_pixels += r * sb.eff_w() * sb.eff_h();
            send_frames(r, -1);
        end
        no_idle = 1'b0;

        do @(posedge i_clk); while (sb.expected_out.size() != 0);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
